/* src/qvt_pkg.sv */
// Shared types and widths for the quaternion vertex transform.
// Used by qvt_cross and quaternion_vertex_transform; depends on nothing else.
package qvt_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int QUAT_W      = 18;
	localparam int TRANS_W     = 26;
	localparam int QFRAC       = 16;
	localparam int ROUND_HALF  = 32768;

	localparam int VEC_W   = COORD_WIDTH + 3;
	localparam int PROD_W  = VEC_W + QUAT_W;
	localparam int RND_W   = PROD_W - QFRAC;
	localparam int CROSS_W = RND_W + 1;
	localparam int RES_W   = (COORD_WIDTH + 9 > TRANS_W + 5) ? COORD_WIDTH + 9 : TRANS_W + 5;
	localparam int DATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = TRANS_W;
	localparam int NUM_STAGES = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUAT_X  = 3'd0,
		CFG_QUAT_Y  = 3'd1,
		CFG_QUAT_Z  = 3'd2,
		CFG_QUAT_W  = 3'd3,
		CFG_TRANS_X = 3'd4,
		CFG_TRANS_Y = 3'd5,
		CFG_TRANS_Z = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] x;
		logic signed [QUAT_W-1:0] y;
		logic signed [QUAT_W-1:0] z;
		logic signed [QUAT_W-1:0] w;
	} quat_t;

	typedef struct packed {
		logic ld_prod;
		logic ld_diff;
	} stage_en_t;

endpackage

/* src/qvt_cross.sv */
// Two-stage pipelined cross product of the quaternion vector part with a vector.
// Each product is rounded to an integer before the subtraction. Depends on qvt_pkg.
module qvt_cross (
	input  logic                                  clk,
	input  qvt_pkg::stage_en_t                    en,
	input  qvt_pkg::quat_t                        quat,
	input  logic signed [qvt_pkg::VEC_W-1:0]      vec_x,
	input  logic signed [qvt_pkg::VEC_W-1:0]      vec_y,
	input  logic signed [qvt_pkg::VEC_W-1:0]      vec_z,
	output logic signed [qvt_pkg::CROSS_W-1:0]    cross_x,
	output logic signed [qvt_pkg::CROSS_W-1:0]    cross_y,
	output logic signed [qvt_pkg::CROSS_W-1:0]    cross_z
);

	logic signed [qvt_pkg::PROD_W-1:0] prod_s1 [6];
	logic signed [qvt_pkg::PROD_W-1:0] prod_d  [6];
	logic signed [qvt_pkg::PROD_W-1:0] biased  [6];
	logic signed [qvt_pkg::RND_W-1:0]  rnd     [6];

	always_comb begin
		prod_d[0] = qvt_pkg::PROD_W'(quat.y) * qvt_pkg::PROD_W'(vec_z);
		prod_d[1] = qvt_pkg::PROD_W'(quat.z) * qvt_pkg::PROD_W'(vec_y);
		prod_d[2] = qvt_pkg::PROD_W'(quat.z) * qvt_pkg::PROD_W'(vec_x);
		prod_d[3] = qvt_pkg::PROD_W'(quat.x) * qvt_pkg::PROD_W'(vec_z);
		prod_d[4] = qvt_pkg::PROD_W'(quat.x) * qvt_pkg::PROD_W'(vec_y);
		prod_d[5] = qvt_pkg::PROD_W'(quat.y) * qvt_pkg::PROD_W'(vec_x);
		for (int i = 0; i < 6; i++) begin
			biased[i] = prod_s1[i] + qvt_pkg::PROD_W'(qvt_pkg::ROUND_HALF);
			rnd[i]    = biased[i][qvt_pkg::PROD_W-1:qvt_pkg::QFRAC];
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_prod) begin
			prod_s1 <= prod_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_diff) begin
			cross_x <= qvt_pkg::CROSS_W'(rnd[0]) - qvt_pkg::CROSS_W'(rnd[1]);
			cross_y <= qvt_pkg::CROSS_W'(rnd[2]) - qvt_pkg::CROSS_W'(rnd[3]);
			cross_z <= qvt_pkg::CROSS_W'(rnd[4]) - qvt_pkg::CROSS_W'(rnd[5]);
		end
	end

endmodule

/* src/quaternion_vertex_transform.sv */
// Quaternion vertex transform: v + 2w(q x v) + 2(q x (q x v)) + 7t, saturated.
// Vertices pass through a five-stage multiply and round pipeline, which takes one
// vertex per cycle while the output is not stalled by m_tready.
// Each stage holds its item while the next one is full, so a stall loses nothing.
// Reset clears all valid bits and loads the identity quaternion and zero translation.
// Depends on qvt_pkg and qvt_cross.
module quaternion_vertex_transform (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// vertex_x, vertex_y, vertex_z from bit 0 up, zero padded to bytes
	input  logic [qvt_pkg::DATA_W-1:0]       s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// moved_x, moved_y, moved_z from bit 0 up, zero padded to bytes
	output logic [qvt_pkg::DATA_W-1:0]       m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [qvt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qvt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = qvt_pkg::COORD_WIDTH;

	qvt_pkg::quat_t                         quat_q;
	logic signed [qvt_pkg::TRANS_W-1:0]     trans_q [3];

	logic [qvt_pkg::NUM_STAGES:1]           stage_vld_q;
	logic [qvt_pkg::NUM_STAGES:1]           stage_rdy;

	logic signed [CW-1:0]                   vin [3];
	logic signed [CW-1:0]                   vert_s1 [3];
	logic signed [CW-1:0]                   vert_s2 [3];
	logic signed [CW-1:0]                   vert_s3 [3];
	logic signed [qvt_pkg::CROSS_W-1:0]     c1_s2 [3];
	logic signed [qvt_pkg::CROSS_W-1:0]     cc_s4 [3];
	logic signed [qvt_pkg::PROD_W-1:0]      wprod_s3 [3];
	logic signed [qvt_pkg::PROD_W-1:0]      wbias [3];
	logic signed [qvt_pkg::RND_W-1:0]       wc_s4 [3];
	logic signed [qvt_pkg::RES_W-1:0]       base_s4 [3];
	logic signed [qvt_pkg::RES_W-1:0]       trans7 [3];
	logic signed [qvt_pkg::RES_W-1:0]       res [3];
	logic signed [CW-1:0]                   moved_s5 [3];
	qvt_pkg::stage_en_t                     en_cross1;
	qvt_pkg::stage_en_t                     en_cross2;

	localparam logic signed [qvt_pkg::RES_W-1:0] SAT_MAX =
		qvt_pkg::RES_W'({1'b0, {(CW - 1){1'b1}}});
	localparam logic signed [qvt_pkg::RES_W-1:0] SAT_MIN = -SAT_MAX - 1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.x   <= '0;
			quat_q.y   <= '0;
			quat_q.z   <= '0;
			quat_q.w   <= qvt_pkg::QUAT_W'(65536);
			trans_q[0] <= '0;
			trans_q[1] <= '0;
			trans_q[2] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (qvt_pkg::cfg_idx_t'(cfg_index))
				qvt_pkg::CFG_QUAT_X:  quat_q.x   <= cfg_data[qvt_pkg::QUAT_W-1:0];
				qvt_pkg::CFG_QUAT_Y:  quat_q.y   <= cfg_data[qvt_pkg::QUAT_W-1:0];
				qvt_pkg::CFG_QUAT_Z:  quat_q.z   <= cfg_data[qvt_pkg::QUAT_W-1:0];
				qvt_pkg::CFG_QUAT_W:  quat_q.w   <= cfg_data[qvt_pkg::QUAT_W-1:0];
				qvt_pkg::CFG_TRANS_X: trans_q[0] <= cfg_data;
				qvt_pkg::CFG_TRANS_Y: trans_q[1] <= cfg_data;
				qvt_pkg::CFG_TRANS_Z: trans_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage takes a new item when it is empty or its item moves on.
	always_comb begin
		stage_rdy[qvt_pkg::NUM_STAGES] = !stage_vld_q[qvt_pkg::NUM_STAGES] || m_tready;
		for (int k = qvt_pkg::NUM_STAGES - 1; k >= 1; k--) begin
			stage_rdy[k] = !stage_vld_q[k] || stage_rdy[k+1];
		end
	end

	assign s_tready = stage_rdy[1];
	assign m_tvalid = stage_vld_q[qvt_pkg::NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_rdy[1]) begin
				stage_vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= qvt_pkg::NUM_STAGES; k++) begin
				if (stage_rdy[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign vin[0] = s_tdata[CW-1:0];
	assign vin[1] = s_tdata[2*CW-1:CW];
	assign vin[2] = s_tdata[3*CW-1:2*CW];

	assign en_cross1.ld_prod = stage_rdy[1];
	assign en_cross1.ld_diff = stage_rdy[2];
	assign en_cross2.ld_prod = stage_rdy[3];
	assign en_cross2.ld_diff = stage_rdy[4];

	qvt_cross u_cross1 (
		.clk     (clk),
		.en      (en_cross1),
		.quat    (quat_q),
		.vec_x   (qvt_pkg::VEC_W'(vin[0])),
		.vec_y   (qvt_pkg::VEC_W'(vin[1])),
		.vec_z   (qvt_pkg::VEC_W'(vin[2])),
		.cross_x (c1_s2[0]),
		.cross_y (c1_s2[1]),
		.cross_z (c1_s2[2])
	);

	qvt_cross u_cross2 (
		.clk     (clk),
		.en      (en_cross2),
		.quat    (quat_q),
		.vec_x   (c1_s2[0][qvt_pkg::VEC_W-1:0]),
		.vec_y   (c1_s2[1][qvt_pkg::VEC_W-1:0]),
		.vec_z   (c1_s2[2][qvt_pkg::VEC_W-1:0]),
		.cross_x (cc_s4[0]),
		.cross_y (cc_s4[1]),
		.cross_z (cc_s4[2])
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wbias[i]  = wprod_s3[i] + qvt_pkg::PROD_W'(qvt_pkg::ROUND_HALF);
			trans7[i] = (qvt_pkg::RES_W'(trans_q[i]) <<< 3) - qvt_pkg::RES_W'(trans_q[i]);
			res[i]    = base_s4[i]
				+ ((qvt_pkg::RES_W'(wc_s4[i]) + qvt_pkg::RES_W'(cc_s4[i])) <<< 1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (stage_rdy[1]) begin
				vert_s1[i] <= vin[i];
			end
			if (stage_rdy[2]) begin
				vert_s2[i] <= vert_s1[i];
			end
			if (stage_rdy[3]) begin
				vert_s3[i]  <= vert_s2[i];
				wprod_s3[i] <= qvt_pkg::PROD_W'(quat_q.w)
					* qvt_pkg::PROD_W'($signed(c1_s2[i][qvt_pkg::VEC_W-1:0]));
			end
			if (stage_rdy[4]) begin
				wc_s4[i]   <= wbias[i][qvt_pkg::PROD_W-1:qvt_pkg::QFRAC];
				base_s4[i] <= qvt_pkg::RES_W'(vert_s3[i]) + trans7[i];
			end
			if (stage_rdy[5]) begin
				priority if (res[i] > SAT_MAX) begin
					moved_s5[i] <= SAT_MAX[CW-1:0];
				end else if (res[i] < SAT_MIN) begin
					moved_s5[i] <= SAT_MIN[CW-1:0];
				end else begin
					moved_s5[i] <= res[i][CW-1:0];
				end
			end
		end
	end

	assign m_tdata = qvt_pkg::DATA_W'({moved_s5[2], moved_s5[1], moved_s5[0]});

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input not ready although the output stage is empty");

	a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> stage_vld_q[1])
		else $error("accepted vertex did not reach the first stage");

	a_pipeline_advances: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready && stage_vld_q[qvt_pkg::NUM_STAGES-1] |=> m_tvalid)
		else $error("item in the last inner stage did not reach the output");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for quaternion_vertex_transform: directed vertices, then random phases.
// Expected vertices are given or come from a fixed-point predictor; needs qvt_pkg and the RTL.
module tb_top;
	import qvt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;
	localparam logic [COORD_WIDTH-1:0] COORD_MIN = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
	localparam logic [COORD_WIDTH-1:0] COORD_MAX = ~COORD_MIN;
	localparam longint OUT_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
	localparam longint OUT_MIN = -OUT_MAX - 1;
	localparam int QUAT_MAX = (1 << (QUAT_W - 1)) - 1;
	localparam int QUAT_ONE = 1 << QFRAC;
	localparam int QUAT_HALF = 1 << (QFRAC - 1);
	localparam int QUAT_RT_HALF = 46341;
	localparam int TRANS_LIMIT = 25600000;
	localparam int ROT_GAIN = 2;
	localparam int SHIFT_GAIN = 7;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_ITEMS = 60;

	typedef enum logic {ROW_CFG, ROW_VTX} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		logic [DATA_W-1:0] vtx;
		bit known;
		logic [DATA_W-1:0] want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	longint rot_q[3] = '{0, 0, 0};
	longint rot_w = QUAT_ONE;
	longint shift_t[3] = '{0, 0, 0};

	logic [DATA_W-1:0] moved_queue[$];
	stim_row_t directed_rows[$];
	int mismatch_count = 0;
	int ready_hold = 0;
	bit steady = 1'b0;
	string field_name[3] = '{"moved_x", "moved_y", "moved_z"};

	quaternion_vertex_transform u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint round_q16(input longint q, input longint a);
		return (q * a + ROUND_HALF) >>> QFRAC;
	endfunction

	function automatic logic [DATA_W-1:0] transform_vertex(input logic [DATA_W-1:0] vtx);
		longint v[3];
		longint c[3];
		longint cc[3];
		longint r;
		logic [DATA_W-1:0] res;
		res = '0;
		for (int i = 0; i < 3; i++)
			v[i] = longint'($signed(vtx[i*COORD_WIDTH +: COORD_WIDTH]));
		for (int i = 0; i < 3; i++)
			c[i] = round_q16(rot_q[(i+1)%3], v[(i+2)%3]) - round_q16(rot_q[(i+2)%3], v[(i+1)%3]);
		for (int i = 0; i < 3; i++)
			cc[i] = round_q16(rot_q[(i+1)%3], c[(i+2)%3])
				- round_q16(rot_q[(i+2)%3], c[(i+1)%3]);
		for (int i = 0; i < 3; i++) begin
			r = v[i] + ROT_GAIN * (round_q16(rot_w, c[i]) + cc[i]) + SHIFT_GAIN * shift_t[i];
			if (r > OUT_MAX)
				r = OUT_MAX;
			if (r < OUT_MIN)
				r = OUT_MIN;
			res[i*COORD_WIDTH +: COORD_WIDTH] = r[COORD_WIDTH-1:0];
		end
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] pack3(input logic [COORD_WIDTH-1:0] x,
			input logic [COORD_WIDTH-1:0] y, input logic [COORD_WIDTH-1:0] z);
		return DATA_W'({z, y, x});
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		directed_rows.insert(directed_rows.size(),
			stim_row_t'{ROW_CFG, idx, data, '0, 1'b0, '0});
	endfunction

	function automatic void add_point(input logic [COORD_WIDTH-1:0] x,
			input logic [COORD_WIDTH-1:0] y, input logic [COORD_WIDTH-1:0] z);
		directed_rows.insert(directed_rows.size(),
			stim_row_t'{ROW_VTX, '0, '0, pack3(x, y, z), 1'b0, '0});
	endfunction

	function automatic void add_known(input logic [COORD_WIDTH-1:0] x,
			input logic [COORD_WIDTH-1:0] y, input logic [COORD_WIDTH-1:0] z,
			input logic [COORD_WIDTH-1:0] ex, input logic [COORD_WIDTH-1:0] ey,
			input logic [COORD_WIDTH-1:0] ez);
		directed_rows.insert(directed_rows.size(),
			stim_row_t'{ROW_VTX, '0, '0, pack3(x, y, z), 1'b1, pack3(ex, ey, ez)});
	endfunction

	// Mostly short pauses, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $urandom_range(1, 2);
		if (r < 9)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [COORD_WIDTH-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3: return COORD_WIDTH'($urandom_range(0, 1 << 18)) - COORD_WIDTH'(1 << 17);
			default: return COORD_WIDTH'($urandom);
		endcase
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_QUAT_X: rot_q[0] = longint'($signed(data[QUAT_W-1:0]));
			CFG_QUAT_Y: rot_q[1] = longint'($signed(data[QUAT_W-1:0]));
			CFG_QUAT_Z: rot_q[2] = longint'($signed(data[QUAT_W-1:0]));
			CFG_QUAT_W: rot_w = longint'($signed(data[QUAT_W-1:0]));
			CFG_TRANS_X: shift_t[0] = longint'($signed(data[TRANS_W-1:0]));
			CFG_TRANS_Y: shift_t[1] = longint'($signed(data[TRANS_W-1:0]));
			CFG_TRANS_Z: shift_t[2] = longint'($signed(data[TRANS_W-1:0]));
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stops sending and waits until every predicted vertex has come back.
	task automatic settle_outputs();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (moved_queue.size() != 0);
	endtask

	task automatic send_vertex(input logic [DATA_W-1:0] vtx, input bit known,
			input logic [DATA_W-1:0] want);
		if (!steady && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= vtx;
		do @(posedge clk); while (!s_tready);
		moved_queue.insert(moved_queue.size(), known ? want : transform_vertex(vtx));
	endtask

	task automatic configure_phase();
		int q[4];
		int axis;
		int t;
		logic [CFG_DATA_W-1:0] d;
		q = '{0, 0, 0, 0};
		axis = $urandom_range(0, 2);
		case ($urandom_range(0, 4))
			0: begin
				q[axis] = $urandom_range(0, 1) ? QUAT_ONE : -QUAT_ONE;
			end
			1: begin
				q[axis] = $urandom_range(0, 1) ? QUAT_RT_HALF : -QUAT_RT_HALF;
				q[3] = QUAT_RT_HALF;
			end
			2: begin
				foreach (q[i])
					q[i] = $urandom_range(0, 1) ? QUAT_HALF : -QUAT_HALF;
			end
			3: begin
				foreach (q[i])
					q[i] = $urandom_range(0, 1) ? QUAT_MAX : -QUAT_MAX - 1;
			end
			default: begin
				foreach (q[i])
					q[i] = $urandom;
			end
		endcase
		for (int i = 0; i < 4; i++) begin
			d = CFG_DATA_W'($urandom);
			d[QUAT_W-1:0] = QUAT_W'(q[i]);
			cfg_write(CFG_IDX_W'(CFG_QUAT_X + i), d);
		end
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 3))
				0: t = 0;
				1: t = $urandom_range(0, 2 * TRANS_LIMIT) - TRANS_LIMIT;
				2: t = $urandom_range(0, 1) ? TRANS_LIMIT : -TRANS_LIMIT;
				default: t = $urandom;
			endcase
			cfg_write(CFG_IDX_W'(CFG_TRANS_X + i), CFG_DATA_W'(t));
		end
		if ($urandom_range(0, 1))
			cfg_write(CFG_IDX_NONE, CFG_DATA_W'($urandom));
	endtask

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			m_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < 30) begin
			ready_hold = gap_len() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_moved
		logic [DATA_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (moved_queue.size() == 0) begin
				$display("%0t unexpected vertex: expected none, got %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = moved_queue.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (m_tdata[i*COORD_WIDTH +: COORD_WIDTH] !== want[i*COORD_WIDTH +: COORD_WIDTH]) begin
						$display("%0t %s: expected %0d, got %0d", $time, field_name[i],
							$signed(want[i*COORD_WIDTH +: COORD_WIDTH]),
							$signed(m_tdata[i*COORD_WIDTH +: COORD_WIDTH]));
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		// Identity rotation and zero translation after reset.
		add_known(0, 0, 0, 0, 0, 0);
		add_known(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		add_known(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		add_known(1, -1, 32'h12345678, 1, -1, 32'h12345678);
		// Largest stated translations, which push the extremes into saturation.
		add_write(CFG_TRANS_X, CFG_DATA_W'(TRANS_LIMIT));
		add_write(CFG_TRANS_Y, CFG_DATA_W'(-TRANS_LIMIT));
		add_known(COORD_MAX, COORD_MIN, 5, COORD_MAX, COORD_MIN, 5);
		add_known(0, 0, 0, 179200000, -179200000, 0);
		// Translations outside the stated range use the raw register value.
		add_write(CFG_TRANS_X, 26'h2000000);
		add_write(CFG_TRANS_Y, 26'h1FFFFFF);
		add_write(CFG_TRANS_Z, 26'h2000000);
		add_known(0, 0, 0, -234881024, 234881017, -234881024);
		add_known(COORD_MIN, COORD_MAX, 1000, COORD_MIN, COORD_MAX, -234880024);
		add_write(CFG_TRANS_X, 0);
		add_write(CFG_TRANS_Y, 0);
		add_write(CFG_TRANS_Z, 0);
		// Half turn about z negates x and y; negating the minimum saturates.
		add_write(CFG_QUAT_Z, CFG_DATA_W'(QUAT_ONE));
		add_write(CFG_QUAT_W, 0);
		add_known(100, 200, 300, -100, -200, 300);
		add_known(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		add_known(COORD_MAX, 1, -1, COORD_MIN + 1, -1, -1);
		// Back to identity with junk above the quaternion width, then an unused index.
		add_write(CFG_QUAT_Z, 26'h3FC0000);
		add_write(CFG_QUAT_W, 26'h3FD0000);
		add_write(CFG_IDX_NONE, 26'h3FFFFFF);
		add_known(7, 8, 9, 7, 8, 9);
		// A quaternion far from unit length scales the vertex as well.
		add_write(CFG_QUAT_X, CFG_DATA_W'(QUAT_MAX));
		add_write(CFG_QUAT_Y, 26'h0020000);
		add_write(CFG_QUAT_Z, 26'h3FE0000);
		add_write(CFG_QUAT_W, CFG_DATA_W'(QUAT_MAX));
		add_point(COORD_MAX, COORD_MAX, COORD_MAX);
		add_point(COORD_MIN, 0, COORD_MAX);
		add_point(1, 2, 3);
		add_point(-1, -1, -1);
		// Half-valued products round halves upward.
		add_write(CFG_QUAT_X, CFG_DATA_W'(QUAT_HALF));
		add_write(CFG_QUAT_Y, 0);
		add_write(CFG_QUAT_Z, 0);
		add_write(CFG_QUAT_W, 0);
		add_point(1, 1, 1);
		add_point(-1, -1, -1);
		add_point(3, -3, 5);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				settle_outputs();
				cfg_write(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_vertex(directed_rows[i].vtx, directed_rows[i].known, directed_rows[i].want);
			end
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle_outputs();
			steady = (phase % 4 == 3);
			configure_phase();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (!steady && $urandom_range(0, 99) == 0)
					settle_outputs();
				send_vertex(pack3(rand_coord(), rand_coord(), rand_coord()), 1'b0, '0);
			end
		end

		settle_outputs();
		repeat (NUM_STAGES * 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
